### src/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg : shared types and constants of the bounded deque
// Depth, field widths, command and status codes, and the transfer structs.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = IDX_W + 1;
    localparam int WORD_W = 32;

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_UPDATE     = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NOMATCH = 2'd3;

    typedef struct packed {
        logic [2:0]               cmd;
        logic signed [WORD_W-1:0] value;
        logic signed [WORD_W-1:0] match_value;
    } bdq_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] entry_count;
    } bdq_result_t;

    typedef struct packed {
        logic                     we;
        logic [IDX_W-1:0]         addr;
        logic signed [WORD_W-1:0] data;
    } bdq_wr_t;

endpackage

### src/bounded_deque_with_update.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_update : bounded double-ended queue with in-place update
// Holds up to DEPTH signed words in a circular store, front to back.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers on a rising edge where start is high and busy is low.
//   item.cmd selects push front, push back, pop front, pop back or update;
//   item.value is the word pushed or the replacement, item.match_value the
//   word that update searches for. Popped words are discarded.
//   Every command gives one result: done is high for exactly one cycle with
//   result.status (ok, empty, full, no match) and result.entry_count, the
//   count held after the command. The receiver cannot hold results off.
// Timing:
//   Push, pop and unknown codes: result in the cycle after the transfer,
//   busy stays low, so one command per cycle.
//   Update: one pass of the shared compare unit per entry, a store read
//   state then a compare state, walking from the front and stopping at the
//   first match or after the back entry; busy is high
//   until the result cycle, where the next command may already transfer.
// Reset:
//   rst_n clears the count and front position; the deque is empty and no
//   result is pending. Store contents are not cleared; only held entries
//   are ever read.
// ----------------------------------------------------------------------------
module bounded_deque_with_update (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  bdq_pkg::bdq_item_t   item,
    output logic                 done,
    output bdq_pkg::bdq_result_t result
);
    import bdq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [IDX_W-1:0]         front_reg, front_next;
    logic [CNT_W-1:0]         occ_reg, occ_next;
    logic [IDX_W-1:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]         scan_cnt_reg, scan_cnt_next;
    logic signed [WORD_W-1:0] value_reg, value_next;
    logic signed [WORD_W-1:0] match_reg, match_next;
    logic                     done_reg, done_next;
    bdq_result_t              result_reg, result_next;

    bdq_wr_t                  mem_wr;
    logic signed [WORD_W-1:0] rdata;

    logic                     accept;
    logic                     full;
    logic                     empty;
    logic [IDX_W-1:0]         front_dec;
    logic [IDX_W-1:0]         front_inc;
    logic [IDX_W-1:0]         pos_inc;
    logic [SUM_W-1:0]         back_sum;
    logic [IDX_W-1:0]         back_slot;
    logic [CNT_W-1:0]         scan_cnt_inc;

    bdq_mem u_mem (
        .clk   (clk),
        .wr    (mem_wr),
        .raddr (pos_reg),
        .rdata (rdata)
    );

    assign accept = start && !busy;
    assign full   = (occ_reg == CNT_W'(DEPTH));
    assign empty  = (occ_reg == '0);

    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign pos_inc   = (pos_reg == IDX_W'(DEPTH - 1)) ? '0 : pos_reg + 1'b1;

    // Slot just past the back; wraps at most once, as front < DEPTH and count <= DEPTH
    assign back_sum  = SUM_W'(front_reg) + SUM_W'(occ_reg);
    assign back_slot = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
                                                   : IDX_W'(back_sum);

    assign scan_cnt_inc = scan_cnt_reg + 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        front_next    = front_reg;
        occ_next      = occ_reg;
        pos_next      = pos_reg;
        scan_cnt_next = scan_cnt_reg;
        value_next    = value_reg;
        match_next    = match_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        mem_wr.we     = 1'b0;
        mem_wr.addr   = pos_reg;
        mem_wr.data   = value_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next          = 1'b1;
                    result_next.status = ST_OK;
                    case (item.cmd)
                        CMD_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                result_next.status = ST_FULL;
                            end
                            else
                            begin
                                mem_wr.we   = 1'b1;
                                mem_wr.addr = front_dec;
                                mem_wr.data = item.value;
                                front_next  = front_dec;
                                occ_next    = occ_reg + 1'b1;
                            end
                        end
                        CMD_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                result_next.status = ST_FULL;
                            end
                            else
                            begin
                                mem_wr.we   = 1'b1;
                                mem_wr.addr = back_slot;
                                mem_wr.data = item.value;
                                occ_next    = occ_reg + 1'b1;
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                result_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                front_next = front_inc;
                                occ_next   = occ_reg - 1'b1;
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            if (empty)
                            begin
                                result_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                occ_next = occ_reg - 1'b1;
                            end
                        end
                        CMD_UPDATE:
                        begin
                            if (empty)
                            begin
                                result_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                // hold the result until the walk finishes
                                done_next     = 1'b0;
                                pos_next      = front_reg;
                                scan_cnt_next = '0;
                                value_next    = item.value;
                                match_next    = item.match_value;
                                state_next    = S_READ;
                            end
                        end
                        default:
                        begin
                            result_next.status = ST_OK;
                        end
                    endcase
                    result_next.entry_count = occ_next;
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (rdata == match_reg)
                begin
                    mem_wr.we               = 1'b1;
                    mem_wr.addr             = pos_reg;
                    mem_wr.data             = value_reg;
                    done_next               = 1'b1;
                    result_next.status      = ST_OK;
                    result_next.entry_count = occ_reg;
                    state_next              = S_IDLE;
                end
                else if (scan_cnt_inc == occ_reg)
                begin
                    done_next               = 1'b1;
                    result_next.status      = ST_NOMATCH;
                    result_next.entry_count = occ_reg;
                    state_next              = S_IDLE;
                end
                else
                begin
                    // advance to the next entry towards the back
                    pos_next      = pos_inc;
                    scan_cnt_next = scan_cnt_inc;
                    state_next    = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            front_reg    <= '0;
            occ_reg      <= '0;
            scan_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            front_reg    <= front_next;
            occ_reg      <= occ_next;
            scan_cnt_reg <= scan_cnt_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        value_reg  <= value_next;
        match_reg  <= match_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy beyond depth");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(accept) || $past(state_reg == S_CMP)))
        else $error("result without a transfer or a finished walk");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (result_reg.entry_count == occ_reg))
        else $error("reported count differs from occupancy");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.status == ST_FULL) |-> (occ_reg == CNT_W'(DEPTH)))
        else $error("full reported on a list with room");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (scan_cnt_reg < occ_reg))
        else $error("walk ran past the back");

endmodule

### src/bdq_mem.sv
// ----------------------------------------------------------------------------
// bdq_mem : entry store of the deque
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bdq_mem (
    input  logic                          clk,
    input  bdq_pkg::bdq_wr_t              wr,
    input  logic [bdq_pkg::IDX_W-1:0]     raddr,
    output logic signed [bdq_pkg::WORD_W-1:0] rdata
);
    import bdq_pkg::*;

    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### test/bdq_checker.sv
// ----------------------------------------------------------------------------
// bdq_checker : deque command predictor and result scoreboard
// Watches the command and result channels of the bounded deque, keeps its own
// copy of the stored words, front position and count, works out the status and
// count for every accepted command and compares each result with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module bdq_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  bdq_pkg::bdq_item_t   item,
    input  logic                 done,
    input  bdq_pkg::bdq_result_t result,
    output int                   mismatch_count,
    output int                   outstanding
);
    import bdq_pkg::*;

    logic signed [WORD_W-1:0] shadow_words [DEPTH];
    int                       shadow_front;
    int                       shadow_held;
    bdq_result_t              predicted_results [$];

    initial
    begin
        mismatch_count = 0;
        outstanding    = 0;
        shadow_front   = 0;
        shadow_held    = 0;
    end

    // Apply one command to the shadow deque and return the status and count.
    function automatic bdq_result_t apply_command(bdq_item_t cmd_in);
        bdq_result_t r;
        int          pos;
        logic        found;
        r.status = ST_OK;
        found    = 1'b0;
        case (cmd_in.cmd)
            CMD_PUSH_FRONT:
                if (shadow_held >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shadow_front = (shadow_front == 0) ? DEPTH - 1 : shadow_front - 1;
                    shadow_words[shadow_front] = cmd_in.value;
                    shadow_held++;
                end
            CMD_PUSH_BACK:
                if (shadow_held >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shadow_words[(shadow_front + shadow_held) % DEPTH] = cmd_in.value;
                    shadow_held++;
                end
            CMD_POP_FRONT:
                if (shadow_held == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    shadow_front = (shadow_front + 1) % DEPTH;
                    shadow_held--;
                end
            CMD_POP_BACK:
                if (shadow_held == 0)
                    r.status = ST_EMPTY;
                else
                    shadow_held--;
            CMD_UPDATE:
                if (shadow_held == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    // only the match nearest the front is replaced
                    for (int k = 0; k < shadow_held; k++)
                    begin
                        pos = (shadow_front + k) % DEPTH;
                        if (!found && shadow_words[pos] == cmd_in.match_value)
                        begin
                            shadow_words[pos] = cmd_in.value;
                            found = 1'b1;
                        end
                    end
                    if (!found)
                        r.status = ST_NOMATCH;
                end
            default:
                r.status = ST_OK;
        endcase
        r.entry_count = shadow_held[CNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        bdq_result_t want;
        if (rst_n)
        begin
            // check the result before queueing this edge's transfer
            if (done)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result with nothing outstanding: status %0d count %0d",
                           result.status, result.entry_count);
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        mismatch_count++;
                    end
                    if (result.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, result.entry_count);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy)
                predicted_results.push_back(apply_command(item));
            outstanding <= predicted_results.size();
        end
    end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench : stimulus and verdict for the bounded deque
// Drives a directed run through empty, single-entry, full and update corner
// cases, then random push/pop/update and unused-code traffic in fill and drain
// phases, gapless for a stretch, and reports the outcome from the checker.
// ----------------------------------------------------------------------------
module testbench;
    import bdq_pkg::*;

    localparam int RANDOM_ITEMS = 1870;
    localparam int CYCLE_LIMIT  = 400000;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    bdq_item_t   item  = '0;
    logic        done;
    bdq_result_t result;
    int          mismatch_count;
    int          outstanding;
    int          cycles = 0;
    logic        gaps_on = 1'b1;
    logic signed [WORD_W-1:0] word_pool [8];

    always #5 clk = ~clk;

    bounded_deque_with_update uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    bdq_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .item           (item),
        .done           (done),
        .result         (result),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Present one command and hold it until it transfers.
    task automatic send(input logic [2:0] c, input logic signed [WORD_W-1:0] v,
                        input logic signed [WORD_W-1:0] m);
        while (gaps_on && $urandom_range(99) < 7)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start            <= 1'b1;
        item.cmd         <= c;
        item.value       <= v;
        item.match_value <= m;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_word();
        return ($urandom_range(99) < 60) ? word_pool[$urandom_range(7)] : $urandom;
    endfunction

    initial
    begin
        int          sent;
        int          push_share;
        int          roll;
        logic [2:0]  c;
        word_pool[0] = 32'sh0000_0000;
        word_pool[1] = -32'sd1;
        word_pool[2] = 32'sh8000_0000;
        word_pool[3] = 32'sh7FFF_FFFF;
        for (int k = 4; k < 8; k++)
            word_pool[k] = $urandom;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list cases
        send(CMD_POP_FRONT, 32'sd5, 32'sd0);
        send(CMD_POP_BACK, 32'sd5, 32'sd0);
        send(CMD_UPDATE, 32'sd5, 32'sd0);
        // single entry: back push sets both ends, pop empties it
        send(CMD_PUSH_BACK, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send(CMD_POP_FRONT, 32'sd0, 32'sd0);
        send(CMD_PUSH_FRONT, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send(CMD_POP_BACK, 32'sd0, 32'sd0);
        // unused codes
        send(3'd5, -32'sd1, -32'sd1);
        send(3'd7, 32'sd0, 32'sd0);
        // fill to the brim with repeated words, then push onto full
        for (int k = 0; k < DEPTH; k++)
            send((k % 2) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, word_pool[k % 4], 32'sd0);
        send(CMD_PUSH_FRONT, 32'sd1, 32'sd0);
        send(CMD_PUSH_BACK, 32'sd1, 32'sd0);
        // several matches, then no match
        send(CMD_UPDATE, 32'sh1234_5678, -32'sd1);
        send(CMD_UPDATE, 32'sd3, 32'sh5A5A_5A5A);

        // random traffic in alternating fill and drain phases
        sent       = 0;
        push_share = 55;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent % 80 == 0)
                push_share = (push_share == 55) ? 25 : 55;
            gaps_on = !(sent >= 700 && sent < 1000);
            roll = $urandom_range(99);
            if (roll < 3)
                c = 3'($urandom_range(7, 5));
            else if (roll < 3 + push_share)
                c = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            else if (roll < 23 + push_share)
                c = CMD_UPDATE;
            else
                c = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
            send(c, pick_word(), pick_word());
            if (c <= CMD_UPDATE)
                sent++;
        end
        start <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (2 * DEPTH + 4) @(posedge clk);

        if (mismatch_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
